// ----- src/dfs_pkg.sv -----
// ============================================================================
// dfs_pkg: shared types, codes and control store of the maze carver
// Holds the transaction payloads, result kinds, direction codes and the
// read-only microprogram that sequences the carver datapath.
// ============================================================================
package dfs_pkg;

   // Wide enough for any coordinate, limit or size register compare
   localparam int CW = 7;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_ADV   = 2'd1,
      KIND_BACK  = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   // Neighbor order: +x, -x, +z, -z
   typedef enum logic [1:0] {
      DIR_PX = 2'd0,
      DIR_MX = 2'd1,
      DIR_PZ = 2'd2,
      DIR_MZ = 2'd3
   } dir_type;

   typedef enum logic [0:0] {
      CSR_CELLS_X = 1'b0,
      CSR_CELLS_Z = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [14:0] random_value;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  cell_x;
      logic [4:0]  cell_z;
      logic [5:0]  grid_x;
      logic [5:0]  grid_z;
      logic [5:0]  wall_x;
      logic [5:0]  wall_z;
   } rsp_type;

   typedef struct packed {
      logic    any;
      dir_type dir;
   } nbr_type;

   // Microprogram addresses
   typedef enum logic [3:0] {
      S_IDLE  = 4'd0,
      S_TOP   = 4'd1,
      S_ROWS  = 4'd2,
      S_ROWM  = 4'd3,
      S_PICK  = 4'd4,
      S_PUSH  = 4'd5,
      S_BACK  = 4'd6,
      S_DONE  = 4'd7,
      S_CLR   = 4'd8,
      S_START = 4'd9
   } step_type;

   // Jump conditions
   typedef enum logic [1:0] {
      JC_GO       = 2'd0,
      JC_DISPATCH = 2'd1,
      JC_CLR      = 2'd2,
      JC_CAND     = 2'd3
   } jc_type;

   typedef struct packed {
      logic     stk_rd;    // read stack top
      logic     rd_near;   // read rows z and z+1, capture top cell
      logic     rd_minus;  // read row z-1
      logic     cap_rows;  // capture rows z and z+1
      logic     cap_pick;  // capture chosen neighbor and its updated row
      logic     row_clr;   // clear one visited row
      logic     init;      // mark and push the start cell
      logic     push;      // mark and push the chosen neighbor
      logic     pop;       // drop the stack top
      logic     emit;      // load the result register
      kind_type emit_kind;
      jc_type   jc;
      step_type target;
   } uword_type;

   function automatic uword_type ucode(input step_type s);
      uword_type u;
      u = '0;
      u.jc = JC_GO;
      u.target = S_IDLE;
      case (s)
         S_IDLE: begin
            u.jc = JC_DISPATCH;
            u.target = S_TOP;
         end
         S_TOP: begin
            u.stk_rd = 1'b1;
            u.target = S_ROWS;
         end
         S_ROWS: begin
            u.rd_near = 1'b1;
            u.target = S_ROWM;
         end
         S_ROWM: begin
            u.rd_minus = 1'b1;
            u.cap_rows = 1'b1;
            u.target = S_PICK;
         end
         S_PICK: begin
            u.cap_pick = 1'b1;
            u.jc = JC_CAND;
            u.target = S_PUSH;
         end
         S_PUSH: begin
            u.push = 1'b1;
            u.emit = 1'b1;
            u.emit_kind = KIND_ADV;
         end
         S_BACK: begin
            u.pop = 1'b1;
            u.emit = 1'b1;
            u.emit_kind = KIND_BACK;
         end
         S_DONE: begin
            u.emit = 1'b1;
            u.emit_kind = KIND_DONE;
         end
         S_CLR: begin
            u.row_clr = 1'b1;
            u.jc = JC_CLR;
            u.target = S_START;
         end
         S_START: begin
            u.init = 1'b1;
            u.emit = 1'b1;
            u.emit_kind = KIND_START;
         end
         default: begin
            u.target = S_IDLE;
         end
      endcase
      return u;
   endfunction

endpackage

// ----- src/dfs_nbr_pick.sv -----
// ============================================================================
// dfs_nbr_pick: neighbor gather and random choice
// Finds the unvisited in-range neighbors of one cell from three visited
// rows and picks number random_value mod count among them.
// ============================================================================
module dfs_nbr_pick
   import dfs_pkg::*;
#(
   parameter int MAX_CELLS_X = 32,
   parameter int MAX_CELLS_Z = 32,
   localparam int XW = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1,
   localparam int ZW = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1
) (
   input  logic [XW-1:0]          cx,
   input  logic [ZW-1:0]          cz,
   input  logic [MAX_CELLS_X-1:0] row_c,
   input  logic [MAX_CELLS_X-1:0] row_p,
   input  logic [MAX_CELLS_X-1:0] row_m,
   input  logic [CW-1:0]          nx_lim,
   input  logic [CW-1:0]          nz_lim,
   input  logic [14:0]            rnd,
   output nbr_type                nbr,
   output logic [XW-1:0]          px,
   output logic [ZW-1:0]          pz
);

   // Fold base-4 digits: 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [14:0] v);
      logic [15:0] w;
      logic [4:0]  s;
      logic [2:0]  t;
      w = {1'b0, v};
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(w[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   logic [CW-1:0]          cx_e, cz_e;
   logic [MAX_CELLS_X-1:0] sh_px, sh_mx, sh_pz, sh_mz;
   logic [3:0]             ok;
   logic [2:0]             count;
   logic [1:0]             k;

   assign cx_e  = CW'(cx);
   assign cz_e  = CW'(cz);
   assign sh_px = row_c >> (cx_e + CW'(1));
   assign sh_mx = row_c >> (cx_e - CW'(1));
   assign sh_pz = row_p >> cx_e;
   assign sh_mz = row_m >> cx_e;

   assign ok[DIR_PX] = (cx_e + CW'(1) < nx_lim) && (cz_e < nz_lim) && !sh_px[0];
   assign ok[DIR_MX] = (cx_e != '0) && (cx_e - CW'(1) < nx_lim) && (cz_e < nz_lim)
                       && !sh_mx[0];
   assign ok[DIR_PZ] = (cx_e < nx_lim) && (cz_e + CW'(1) < nz_lim) && !sh_pz[0];
   assign ok[DIR_MZ] = (cx_e < nx_lim) && (cz_e != '0) && (cz_e - CW'(1) < nz_lim)
                       && !sh_mz[0];

   assign count = 3'($countones(ok));

   always_comb begin
      case (count)
         3'd2:    k = {1'b0, rnd[0]};
         3'd3:    k = mod3(rnd);
         3'd4:    k = rnd[1:0];
         default: k = 2'd0;
      endcase
   end

   // Select the k-th set candidate in order
   always_comb begin
      logic [1:0] seen;
      seen = '0;
      nbr.any = (count != 3'd0);
      nbr.dir = DIR_PX;
      for (int i = 0; i < 4; i++) begin
         if (ok[i] && (seen == k)) begin
            nbr.dir = dir_type'(2'(i));
         end
         seen = seen + 2'(ok[i]);
      end
   end

   always_comb begin
      px = cx;
      pz = cz;
      case (nbr.dir)
         DIR_PX:  px = XW'(cx_e + CW'(1));
         DIR_MX:  px = XW'(cx_e - CW'(1));
         DIR_PZ:  pz = ZW'(cz_e + CW'(1));
         DIR_MZ:  pz = ZW'(cz_e - CW'(1));
         default: px = cx;
      endcase
   end

endmodule

// ----- src/dfs_maze_carver.sv -----
// ============================================================================
// dfs_maze_carver: randomized depth-first maze carver
// Recursive backtracker over a cells_x by cells_z grid with an explicit
// cell stack and a row-organized visited map, sequenced by a microprogram.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  req     | in        | req_valid/req_stall| req_type: cmd, random_value
//  rsp     | out       | rsp_valid/rsp_stall| rsp_type: kind, cell, grid, wall
//  csr     | in        | csr_valid/csr_ready| csr_index, csr_data (6 bits)
//
//  A step transaction runs from accept to the next accept through stack
//  read, two visited-map row reads, pick, then push or pop. A step on an
//  empty stack goes straight to the done result. A start transaction clears
//  the visited map one row per cycle, then marks and pushes the start cell.
//  Reset is synchronous; the stack is empty and both sizes are 10 after it.
//  The result register decouples the sides: a waiting result stalls only
//  the final step of the next transaction.
//
module dfs_maze_carver
   import dfs_pkg::*;
#(
   parameter int MAX_CELLS_X = 32,
   parameter int MAX_CELLS_Z = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [5:0] csr_data
);

   localparam int XW         = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
   localparam int ZW         = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1;
   localparam int CELL_COUNT = MAX_CELLS_X * MAX_CELLS_Z;
   localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int DW         = $clog2(CELL_COUNT + 1);
   localparam logic [MAX_CELLS_X-1:0] ONE_ROW = MAX_CELLS_X'(1);

   // Sizes
   logic [5:0]    cells_x_ff, cells_z_ff;
   logic [CW-1:0] cx_cfg, cz_cfg, nx_lim, nz_lim;

   // Sequencer
   step_type  step_ff, step_in;
   uword_type uw;
   logic      req_fire, out_busy, fire, rsp_load;

   // Datapath
   logic [DW-1:0]          depth_ff;
   logic                   full;
   logic [ZW-1:0]          clr_ff;
   logic [14:0]            rnd_ff;
   logic [XW-1:0]          cx_ff, px_ff, px;
   logic [ZW-1:0]          cz_ff, pz_ff, pz;
   logic [MAX_CELLS_X-1:0] row_c_ff, row_p_ff, wrow_ff, wrow_in;
   nbr_type                nbr;

   // Stack memory
   logic [XW+ZW-1:0] stack_mem [CELL_COUNT];
   logic [XW+ZW-1:0] stk_rd_ff;
   logic [XW-1:0]    stk_x;
   logic [ZW-1:0]    stk_z;

   // Visited map, one row of x bits per z
   logic [MAX_CELLS_X-1:0] vmap [MAX_CELLS_Z];
   logic [MAX_CELLS_X-1:0] rowa_ff, rowb_ff, vm_wdata;
   logic [ZW-1:0]          addr_a, addr_b, vm_waddr, zm;
   logic [CW-1:0]          zp_e;
   logic                   vm_we;

   // Result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [CW-1:0] px_e, pz_e, cxo_e, czo_e, wx_sum, wz_sum;

   // ------------------------------------------------------------------
   // Configuration: always ready; unenforced rule: written by the user only while idle
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= 6'd10;
         cells_z_ff <= 6'd10;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CELLS_X: cells_x_ff <= csr_data;
            CSR_CELLS_Z: cells_z_ff <= csr_data;
            default:     cells_x_ff <= cells_x_ff;
         endcase
      end
   end

   // Clamp: zero counts as one, oversize as the maximum
   assign cx_cfg = CW'(cells_x_ff);
   assign cz_cfg = CW'(cells_z_ff);
   assign nx_lim = (cx_cfg == '0) ? CW'(1) :
                   (cx_cfg > CW'(MAX_CELLS_X)) ? CW'(MAX_CELLS_X) : cx_cfg;
   assign nz_lim = (cz_cfg == '0) ? CW'(1) :
                   (cz_cfg > CW'(MAX_CELLS_Z)) ? CW'(MAX_CELLS_Z) : cz_cfg;

   // ------------------------------------------------------------------
   // Sequencer: control word from the program table, conditional jumps
   // ------------------------------------------------------------------
   assign uw        = ucode(step_ff);
   assign req_stall = (step_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   // Hold an emitting step, with no side effects, while the result waits
   assign fire      = !(uw.emit && out_busy);
   assign rsp_load  = uw.emit && fire;
   assign full      = (depth_ff >= DW'(CELL_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         case (uw.jc)
            JC_GO: begin
               step_in = uw.target;
            end
            JC_DISPATCH: begin
               if (req_fire) begin
                  if (req_data.cmd == CMD_START) begin
                     step_in = S_CLR;
                  end else if (depth_ff == '0) begin
                     step_in = S_DONE;
                  end else begin
                     step_in = uw.target;
                  end
               end
            end
            JC_CLR: begin
               if (clr_ff == ZW'(MAX_CELLS_Z - 1)) begin
                  step_in = uw.target;
               end
            end
            JC_CAND: begin
               step_in = (nbr.any && !full) ? uw.target : S_BACK;
            end
            default: begin
               step_in = S_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Control registers: stack depth, clear sweep row
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (req_fire && req_data.cmd == CMD_START) begin
            clr_ff <= '0;
         end else if (uw.row_clr && clr_ff != ZW'(MAX_CELLS_Z - 1)) begin
            clr_ff <= clr_ff + ZW'(1);
         end
         if (fire && uw.init) begin
            depth_ff <= DW'(1);
         end else if (fire && uw.push) begin
            depth_ff <= depth_ff + DW'(1);
         end else if (fire && uw.pop) begin
            depth_ff <= depth_ff - DW'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stack memory: read the top, write at depth
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (uw.stk_rd) begin
         stk_rd_ff <= stack_mem[AW'(depth_ff - DW'(1))];
      end
      if (fire && uw.init) begin
         stack_mem[AW'(0)] <= '0;
      end else if (fire && uw.push) begin
         stack_mem[depth_ff[AW-1:0]] <= {pz_ff, px_ff};
      end
   end

   assign stk_x = stk_rd_ff[XW-1:0];
   assign stk_z = stk_rd_ff[XW+ZW-1:XW];

   // ------------------------------------------------------------------
   // Visited map: two read ports, one write port
   // ------------------------------------------------------------------
   // Out-of-range row reads fall back to the current row; the picker
   // masks those neighbors by range anyway
   assign zp_e   = CW'(stk_z) + CW'(1);
   assign addr_b = (zp_e < CW'(MAX_CELLS_Z)) ? ZW'(zp_e) : stk_z;
   assign zm     = (cz_ff == '0) ? cz_ff : cz_ff - ZW'(1);
   assign addr_a = uw.rd_minus ? zm : stk_z;

   assign vm_we    = fire && (uw.row_clr || uw.init || uw.push);
   assign vm_waddr = uw.row_clr ? clr_ff : (uw.init ? ZW'(0) : pz_ff);
   assign vm_wdata = uw.row_clr ? '0 : (uw.init ? ONE_ROW : wrow_ff);

   always_ff @(posedge clock) begin
      if (uw.rd_near || uw.rd_minus) begin
         rowa_ff <= vmap[addr_a];
      end
      if (uw.rd_near) begin
         rowb_ff <= vmap[addr_b];
      end
      if (vm_we) begin
         vmap[vm_waddr] <= vm_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Capture registers along the walk
   // ------------------------------------------------------------------
   always_comb begin
      case (nbr.dir)
         DIR_PZ:  wrow_in = row_p_ff;
         DIR_MZ:  wrow_in = rowa_ff;
         default: wrow_in = row_c_ff;
      endcase
      wrow_in = wrow_in | (ONE_ROW << px);
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rnd_ff <= req_data.random_value;
      end
      if (uw.rd_near) begin
         cx_ff <= stk_x;
         cz_ff <= stk_z;
      end
      if (uw.cap_rows) begin
         row_c_ff <= rowa_ff;
         row_p_ff <= rowb_ff;
      end
      if (uw.cap_pick) begin
         px_ff   <= px;
         pz_ff   <= pz;
         wrow_ff <= wrow_in;
      end
   end

   dfs_nbr_pick #(
      .MAX_CELLS_X (MAX_CELLS_X),
      .MAX_CELLS_Z (MAX_CELLS_Z)
   ) u_pick (
      .cx     (cx_ff),
      .cz     (cz_ff),
      .row_c  (row_c_ff),
      .row_p  (row_p_ff),
      .row_m  (rowa_ff),
      .nx_lim (nx_lim),
      .nz_lim (nz_lim),
      .rnd    (rnd_ff),
      .nbr    (nbr),
      .px     (px),
      .pz     (pz)
   );

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   assign px_e   = CW'(px_ff);
   assign pz_e   = CW'(pz_ff);
   assign cxo_e  = CW'(cx_ff);
   assign czo_e  = CW'(cz_ff);
   // Wall sits between the two cells: cx + px + 1 in grid coordinates
   assign wx_sum = cxo_e + px_e + CW'(1);
   assign wz_sum = czo_e + pz_e + CW'(1);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.kind = uw.emit_kind;
      case (uw.emit_kind)
         KIND_START: begin
            rsp_data_in.grid_x = 6'd1;
            rsp_data_in.grid_z = 6'd1;
            rsp_data_in.wall_x = 6'd1;
            rsp_data_in.wall_z = 6'd1;
         end
         KIND_ADV: begin
            rsp_data_in.cell_x = px_e[4:0];
            rsp_data_in.cell_z = pz_e[4:0];
            rsp_data_in.grid_x = {px_e[4:0], 1'b1};
            rsp_data_in.grid_z = {pz_e[4:0], 1'b1};
            rsp_data_in.wall_x = wx_sum[5:0];
            rsp_data_in.wall_z = wz_sum[5:0];
         end
         KIND_BACK: begin
            rsp_data_in.cell_x = cxo_e[4:0];
            rsp_data_in.cell_z = czo_e[4:0];
         end
         default: begin
            rsp_data_in.kind = KIND_DONE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_START) |=> (step_ff == S_CLR && clr_ff == '0))
      else $error("start did not enter the clear sweep");

   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_STEP && depth_ff == '0) |=> (step_ff == S_DONE))
      else $error("step on empty stack did not report done");

   a_pick_branch: assert property (@(posedge clock) disable iff (reset)
      (step_ff == S_PICK) |=> ((step_ff == S_PUSH) == $past(nbr.any && !full)))
      else $error("pick took the wrong branch");

   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      (step_ff == S_PUSH && fire) |=> (depth_ff == $past(depth_ff) + DW'(1)))
      else $error("push did not grow the stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting result was overwritten or dropped");

endmodule
